// ===== hdl/srpv3_memory_server_core_assert.svh =====
// Assertion macros for the SRPv3 memory server core.
// Each macro checks that a condition implies a result on the next edge, or
// that a condition never holds. Both forms are empty when SYNTHESIS is set.
`ifndef SRPV3_MEMORY_SERVER_CORE_ASSERT_SVH
`define SRPV3_MEMORY_SERVER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SRPV3_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`define SRPV3_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");
`else
`define SRPV3_ASSERT_NEXT(label, clk, rst, cond, prop)
`define SRPV3_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== hdl/srpv3_pkg.sv =====
// ----------------------------------------------------------------------------
// srpv3_pkg
// Beat types and protocol constants for the SRPv3 memory server.
// ----------------------------------------------------------------------------
package srpv3_pkg;
  localparam int unsigned HEAD_LEN = 20;
  localparam int unsigned TAIL_LEN = 4;
  localparam logic [7:0] VERSION3 = 8'h03;
  localparam logic [1:0] OP_READ = 2'h0;
  localparam logic [1:0] OP_WRITE = 2'h1;
  localparam logic [1:0] OP_POSTED = 2'h2;
  localparam logic [1:0] OP_BAD = 2'h3;
  localparam logic CMD_REQ = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
    logic       frame_end;
    logic       frame_error;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] resp_byte;
    logic       resp_last;
  } out_beat_t;
endpackage

// ===== hdl/srpv3_ram.sv =====
// ----------------------------------------------------------------------------
// srpv3_ram
// Single-port synchronous byte RAM with a registered read.
// ----------------------------------------------------------------------------
module srpv3_ram #(
  parameter int unsigned AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);
  logic [7:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/srpv3_memory_server_core.sv =====
// ----------------------------------------------------------------------------
// srpv3_memory_server_core
// SRPv3 register-access server over a byte stream, memory based.
// ----------------------------------------------------------------------------
// Usage: drive one input beat (opcode, data_byte, frame_end, frame_error)
// with start while busy is low. Opcode 0 beats carry request frame bytes;
// opcode 1 beats pull one byte of the queued response.
// Headers are kept in a small flop array; the payload goes to a 4K buffer
// RAM and committed data lives in the byte memory RAM (2**MEM_AW deep).
// The frame_end beat of a request adds a decode state (S_EVAL, busy)
// while the finished header is checked. An accepted write or posted
// write then copies reqSize bytes from the buffer, each as a buffer
// read followed by a memory write.
// Pull: a header or tail byte is registered onto result at the accepting
// edge; a memory byte keeps busy high for the RAM read (S_PULL) and is
// registered out of S_PULL. Each result is on result for one cycle,
// flagged by done. The receiver cannot stall, so no result is held back.
// A pull with nothing pending gives no result.
// Reset (rst, synchronous) clears counters and the pending flag; both
// RAMs are left uninitialized, and no clearing pass is run.
// ----------------------------------------------------------------------------
module srpv3_memory_server_core #(
  parameter int unsigned MEM_AW = 16,
  parameter int unsigned MAX_REQ = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  srpv3_pkg::in_beat_t   item,
  output logic                  done,
  output srpv3_pkg::out_beat_t  result
);
  import srpv3_pkg::*;
`include "srpv3_memory_server_core_assert.svh"

  localparam int unsigned PAW = $clog2(MAX_REQ);
  localparam int unsigned CW = $clog2(HEAD_LEN + MAX_REQ + 2);
  localparam int unsigned LW = $clog2(MAX_REQ + 1);
  localparam int unsigned PW = $clog2(HEAD_LEN + MAX_REQ + TAIL_LEN + 1);
  localparam logic [CW-1:0] SEEN_CAP = CW'(HEAD_LEN + MAX_REQ + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_COPY = 2'd1;
  localparam logic [1:0] S_PULL = 2'd2;
  localparam logic [1:0] S_EVAL = 2'd3;

  logic [1:0] state;
  logic [7:0] hdr [0:HEAD_LEN-1];
  logic [7:0] rhdr [0:HEAD_LEN-1];
  logic [CW-1:0] seen;
  logic err_seen;
  logic pending;
  logic [PW-1:0] pos;
  logic [LW-1:0] rlen;
  logic [MEM_AW-1:0] raddr;
  logic [LW-1:0] cidx;
  logic cphase;
  logic [MEM_AW-1:0] caddr;
  logic [LW-1:0] clen;

  // buffer RAM controls
  logic bwe;
  logic [PAW-1:0] baddr;
  logic [7:0] bdata;
  // memory RAM controls
  logic mwe;
  logic [MEM_AW-1:0] maddr;
  logic [7:0] mrdata;

  logic acc;
  assign acc = start && !busy;
  assign busy = (state != S_IDLE);

  // header decode
  logic [31:0] size_m1;
  logic [32:0] size;
  logic [MEM_AW-1:0] haddr;
  logic [1:0] op;
  logic [CW:0] seen_n;
  always_comb begin
    size_m1 = {hdr[19], hdr[18], hdr[17], hdr[16]};
    size = {1'b0, size_m1} + 33'd1;
    haddr = MEM_AW'({hdr[15], hdr[14], hdr[13], hdr[12],
                     hdr[11], hdr[10], hdr[9], hdr[8]});
    op = hdr[1][1:0];
  end
  // byte count including the beat taken now
  always_comb begin
    seen_n = (CW+1)'(seen) + (CW+1)'(1);
  end

  logic [CW-1:0] pidx;
  assign pidx = seen - CW'(HEAD_LEN);

  always_comb begin
    bwe = 1'b0;
    baddr = pidx[PAW-1:0];
    bdata = item.data_byte;
    mwe = 1'b0;
    maddr = raddr + MEM_AW'(pos - PW'(HEAD_LEN));
    if (state == S_IDLE) begin
      if (acc && item.opcode == CMD_REQ && seen >= CW'(HEAD_LEN) &&
          pidx < CW'(MAX_REQ)) begin
        bwe = 1'b1;
      end
    end else if (state == S_COPY) begin
      baddr = cidx[PAW-1:0];
      maddr = caddr + MEM_AW'(cidx);
      mwe = cphase;
    end
    bdata = item.data_byte;
  end

  logic [7:0] bq;
  logic [7:0] bmem [0:MAX_REQ-1];
  always_ff @(posedge clk) begin
    if (bwe) begin
      bmem[baddr] <= bdata;
    end
    bq <= bmem[baddr];
  end

  srpv3_ram #(.AW(MEM_AW)) u_mem (
    .clk(clk), .we(mwe), .addr(maddr), .wdata(bq), .rdata(mrdata)
  );

  // the frame_end beat may itself write header byte 19, so the frame is
  // checked in S_EVAL on the following cycle
  logic eval_ok;
  logic [CW-1:0] eval_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seen <= '0;
      err_seen <= 1'b0;
      pending <= 1'b0;
      pos <= '0;
      rlen <= '0;
      raddr <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc && item.opcode == CMD_REQ) begin
            if (seen < CW'(HEAD_LEN)) hdr[seen[4:0]] <= item.data_byte;
            if (item.frame_end) begin
              eval_ok <= !err_seen && !item.frame_error && !pending &&
                         seen_n >= (CW+1)'(HEAD_LEN);
              eval_seen <= (seen < SEEN_CAP) ? seen_n[CW-1:0] : seen;
              seen <= '0;
              err_seen <= 1'b0;
              state <= S_EVAL;
            end else begin
              if (item.frame_error) err_seen <= 1'b1;
              if (seen < SEEN_CAP) seen <= seen_n[CW-1:0];
            end
          end else if (acc && pending) begin
            if (pos >= PW'(HEAD_LEN) && pos < PW'(HEAD_LEN) + PW'(rlen)) begin
              state <= S_PULL;
            end else begin
              done <= 1'b1;
              result.resp_byte <= (pos < PW'(HEAD_LEN)) ? rhdr[pos[4:0]] : 8'h00;
              result.resp_last <= (pos + 1'b1 >= PW'(HEAD_LEN) + PW'(rlen) +
                                   PW'(TAIL_LEN));
              if (pos + 1'b1 >= PW'(HEAD_LEN) + PW'(rlen) + PW'(TAIL_LEN)) begin
                pending <= 1'b0;
                pos <= '0;
              end else begin
                pos <= pos + 1'b1;
              end
            end
          end
        end
        S_EVAL: begin
          state <= S_IDLE;
          if (eval_ok && hdr[0] == VERSION3 && op != OP_BAD &&
              size <= 33'(MAX_REQ) &&
              (op == OP_READ || size <= 33'(eval_seen) - 33'(HEAD_LEN))) begin
            if (op != OP_READ) begin
              clen <= LW'(size);
              caddr <= haddr;
              cidx <= '0;
              cphase <= 1'b0;
              state <= S_COPY;
            end
            if (op != OP_POSTED) begin
              pending <= 1'b1;
              pos <= '0;
              rlen <= LW'(size);
              raddr <= haddr;
              for (int i = 0; i < HEAD_LEN; i++) rhdr[i] <= hdr[i];
            end
          end
        end
        S_COPY: begin
          // phase 0 reads the buffer, phase 1 writes the byte to memory
          cphase <= !cphase;
          if (cphase) begin
            if (cidx + 1'b1 == clen) state <= S_IDLE;
            cidx <= cidx + 1'b1;
          end
        end
        S_PULL: begin
          done <= 1'b1;
          result.resp_byte <= mrdata;
          result.resp_last <= 1'b0;
          pos <= pos + 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SRPV3_ASSERT_NEVER(a_copy_pull, clk, rst, state == S_PULL && mwe)
  `SRPV3_ASSERT_NEVER(a_write_copy, clk, rst, mwe && state != S_COPY)
  `SRPV3_ASSERT_NEXT(a_pull_done, clk, rst, state == S_PULL, done)
  `SRPV3_ASSERT_NEVER(a_last_clears, clk, rst, done && result.resp_last && pending)
  `SRPV3_ASSERT_NEXT(a_eval_once, clk, rst, state == S_EVAL, state != S_EVAL)
endmodule

// ===== verif/srpv3_memory_server_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpv3_memory_server_checker
// Watches accepted input beats, predicts response bytes and checks them.
// ----------------------------------------------------------------------------
module srpv3_memory_server_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  srpv3_pkg::in_beat_t  item,
  input  logic                 done,
  input  srpv3_pkg::out_beat_t result,
  output int                   fail_count,
  output int                   pending_count,
  output logic                 open_resp
);
  import srpv3_pkg::*;

  localparam int unsigned MEM_SIZE = 65536;
  localparam int unsigned REQ_MAX = 4096;
  localparam int unsigned SEEN_CAP = HEAD_LEN + REQ_MAX + 1;

  logic [7:0] hdr_q [HEAD_LEN];
  logic [7:0] pay_q [REQ_MAX];
  logic [7:0] mem_img [MEM_SIZE];
  logic [7:0] rsp_hdr [HEAD_LEN];
  int unsigned seen_cnt, rsp_pos, rsp_len, rsp_addr;
  bit err_flag, rsp_open;
  out_beat_t resp_q[$];

  assign pending_count = resp_q.size();
  assign open_resp = rsp_open;

  function automatic logic [31:0] hdr_word(int unsigned at);
    return {hdr_q[at + 3], hdr_q[at + 2], hdr_q[at + 1], hdr_q[at]};
  endfunction

  task automatic close_frame();
    logic [1:0] op;
    longint unsigned sz;
    int unsigned base;
    begin
      op = hdr_q[1][1:0];
      sz = longint'(hdr_word(16)) + 1;
      base = hdr_word(8) % MEM_SIZE;
      if (err_flag || rsp_open || seen_cnt < HEAD_LEN) return;
      if (hdr_q[0] != VERSION3 || op == OP_BAD || sz > REQ_MAX) return;
      if (op == OP_WRITE || op == OP_POSTED) begin
        if (seen_cnt < HEAD_LEN + sz) return;
        for (int i = 0; i < sz; i++) mem_img[(base + i) % MEM_SIZE] = pay_q[i];
      end
      if (op == OP_POSTED) return;
      for (int i = 0; i < HEAD_LEN; i++) rsp_hdr[i] = hdr_q[i];
      rsp_len = 32'(sz);
      rsp_addr = base;
      rsp_pos = 0;
      rsp_open = 1;
    end
  endtask

  task automatic take_beat(in_beat_t b);
    out_beat_t o;
    begin
      if (b.opcode == CMD_REQ) begin
        if (b.frame_error) err_flag = 1;
        if (seen_cnt < HEAD_LEN) hdr_q[seen_cnt] = b.data_byte;
        else if (seen_cnt - HEAD_LEN < REQ_MAX) pay_q[seen_cnt - HEAD_LEN] = b.data_byte;
        if (seen_cnt < SEEN_CAP) seen_cnt++;
        if (b.frame_end) begin
          close_frame();
          seen_cnt = 0;
          err_flag = 0;
        end
      end else if (rsp_open) begin
        o.resp_byte = 8'h00;
        if (rsp_pos < HEAD_LEN) o.resp_byte = rsp_hdr[rsp_pos];
        else if (rsp_pos - HEAD_LEN < rsp_len)
          o.resp_byte = mem_img[(rsp_addr + rsp_pos - HEAD_LEN) % MEM_SIZE];
        o.resp_last = (rsp_pos + 1 >= HEAD_LEN + rsp_len + TAIL_LEN);
        resp_q.push_back(o);
        if (o.resp_last) begin
          rsp_open = 0;
          rsp_pos = 0;
        end else rsp_pos++;
      end
    end
  endtask

  always @(posedge clk) begin
    out_beat_t exp_b;
    if (rst) begin
      seen_cnt = 0; err_flag = 0; rsp_open = 0; rsp_pos = 0;
      rsp_len = 0; rsp_addr = 0; fail_count = 0;
      resp_q.delete();
    end else begin
      if (done) begin
        if (resp_q.size() == 0) begin
          $error("unexpected result beat byte=%0h", result.resp_byte);
          fail_count++;
        end else begin
          exp_b = resp_q.pop_front();
          if (result.resp_byte !== exp_b.resp_byte) begin
            $error("resp_byte exp %0h got %0h", exp_b.resp_byte, result.resp_byte);
            fail_count++;
          end
          if (result.resp_last !== exp_b.resp_last) begin
            $error("resp_last exp %0b got %0b", exp_b.resp_last, result.resp_last);
            fail_count++;
          end
        end
      end
      if (start && !busy) take_beat(item);
    end
  end
endmodule

// ===== verif/srpv3_memory_server_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpv3_memory_server_core_tb
// Drives request frames and pulls into the server core; a side checker
// predicts every response beat and counts mismatches.
// ----------------------------------------------------------------------------
module srpv3_memory_server_core_tb;
  import srpv3_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done;
  in_beat_t item = '0;
  out_beat_t result;
  int fail_count, pending_count;
  logic open_resp;
  int beats_sent = 0;
  longint cycle_cnt = 0;
  // Addresses marked as written; the read frames built for random traffic target only these.
  bit written [65536];

  always #5 clk = ~clk;

  srpv3_memory_server_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  srpv3_memory_server_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .fail_count(fail_count),
    .pending_count(pending_count), .open_resp(open_resp)
  );

  // Watchdog: generous bound over the slowest legal run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 3000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // One beat: hold start until the beat is taken, then maybe idle.
  task automatic send_beat(logic op, logic [7:0] b, logic fe, logic er);
    begin
      item <= '{opcode: op, data_byte: b, frame_end: fe, frame_error: er};
      start <= 1;
      @(posedge clk);
      while (busy) @(posedge clk);
      beats_sent++;
      if ($urandom_range(0, 3) == 0) begin
        start <= 0;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 2))
          @(posedge clk);
      end
    end
  endtask

  // Whole frame. ver/op/addr/sz go into the header; len sets bytes sent.
  task automatic send_frame(logic [7:0] ver, logic [7:0] opb, logic [63:0] addr,
                            logic [31:0] szm1, int len, bit err);
    logic [7:0] hb [20];
    begin
      for (int i = 0; i < 20; i++) hb[i] = 8'($urandom);
      hb[0] = ver; hb[1] = opb;
      for (int i = 0; i < 8; i++) hb[8 + i] = addr[8*i +: 8];
      for (int i = 0; i < 4; i++) hb[16 + i] = szm1[8*i +: 8];
      for (int i = 0; i < len; i++)
        send_beat(CMD_REQ, i < 20 ? hb[i] : 8'($urandom), i == len - 1,
                  err && i == len / 2);
    end
  endtask

  task automatic drain_resp(int n);
    for (int i = 0; i < n; i++)
      send_beat(CMD_PULL, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Pull until no response is open, so that the next write commits.
  task automatic close_resp();
    start <= 0;
    #1;
    while (open_resp) begin
      @(posedge clk);
      send_beat(CMD_PULL, 8'h00, 1'b0, 1'b0);
      start <= 0;
      #1;
    end
    @(posedge clk);
  endtask

  task automatic mark(int unsigned a, int n);
    for (int i = 0; i < n; i++) written[(a + i) % 65536] = 1;
  endtask

  function automatic bit all_written(int unsigned a, int n);
    for (int i = 0; i < n; i++) if (!written[(a + i) % 65536]) return 0;
    return 1;
  endfunction

  initial begin
    int unsigned a;
    int n, kind;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: pull idle, writes at extremes, wrap, read back, drops.
    drain_resp(2);
    send_frame(VERSION3, {6'h3f, OP_POSTED}, 64'hffff_ffff_ffff_fffe, 3, 24, 0);
    mark(16'hfffe, 4);
    send_frame(VERSION3, {6'h00, OP_WRITE}, 64'h0, 0, 21, 0);
    mark(0, 1);
    send_frame(VERSION3, {6'h00, OP_READ}, 64'h0, 0, 20, 0);  // pending: discarded
    drain_resp(25);
    send_frame(VERSION3, {6'h00, OP_READ}, 64'h1_0000_fffe, 3, 20, 0);
    drain_resp(30);
    send_frame(VERSION3, {6'h00, OP_BAD}, 0, 0, 25, 0);
    send_frame(8'h02, {6'h00, OP_READ}, 0, 0, 20, 0);
    send_frame(VERSION3, {6'h00, OP_READ}, 0, 0, 19, 0);
    send_frame(VERSION3, {6'h00, OP_READ}, 0, 0, 20, 1);
    send_frame(VERSION3, {6'h00, OP_WRITE}, 0, 4, 22, 0);      // short write
    send_frame(VERSION3, {6'h00, OP_READ}, 0, 32'hffff_ffff, 20, 0); // oversize
    send_frame(VERSION3, {6'h00, OP_READ}, 0, 4096, 20, 0);
    drain_resp(3);
    // One longer posted write.
    send_frame(VERSION3, {6'h00, OP_POSTED}, 64'h8000, 31, 52, 0);
    mark(16'h8000, 32);
    // Pause until everything expected has arrived.
    start <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    // Random traffic, mostly well-formed.
    while (beats_sent < 500) begin
      kind = $urandom_range(0, 9);
      a = $urandom;
      n = $urandom_range(1, 16);
      if (kind < 4) begin
        close_resp();
        send_frame(VERSION3, {6'($urandom), $urandom_range(0, 1) ? OP_WRITE : OP_POSTED},
                   {32'($urandom), 32'(a)}, n - 1, 20 + n + $urandom_range(0, 2), 0);
        if (kind < 1) drain_resp(24 + n);
        mark(a % 65536, n);
      end else if (kind < 7) begin
        a = $urandom_range(0, 1) ? 16'h8000 + $urandom_range(0, 31) : a;
        if (all_written(a % 65536, n)) begin
          send_frame(VERSION3, {6'h00, OP_READ}, {32'($urandom), 32'(a)}, n - 1, 20, 0);
          drain_resp($urandom_range(0, 3) == 0 ? $urandom_range(0, 50) : 24 + n);
        end
      end else if (kind == 7) begin
        send_frame($urandom_range(0, 1) ? VERSION3 : 8'($urandom), 8'($urandom),
                   {32'($urandom), 32'(a)}, $urandom_range(0, 1) ? 32'($urandom) : 32'(n),
                   $urandom_range(1, 24), 1'($urandom_range(0, 1)));
        drain_resp(2);
      end else begin
        drain_resp($urandom_range(1, 40));
      end
    end
    close_resp();  // finishes any open response
    start <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/srpv3_pkg.sv
hdl/srpv3_ram.sv
hdl/srpv3_memory_server_core.sv
verif/srpv3_memory_server_checker.sv
verif/srpv3_memory_server_core_tb.sv
